// ===== design/mad_pkg.sv =====
package mad_pkg;

  // width of the window length write data
  localparam int unsigned CFG_W = 6;

  // window length after reset
  localparam int unsigned RESET_WINDOW = 8;

  // control from the sequencer to the window store
  typedef struct packed {
    logic clear;   // drop all samples and zero the sum
    logic rd_en;   // fetch the oldest sample at the write position
    logic upd;     // replace it with the new sample and update the sum
  } win_cmd_t;

endpackage

// ===== design/mad_window.sv =====
module mad_window #(
  parameter int unsigned MAX_WINDOW  = 32,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned LEN_W       = 6,
  parameter int unsigned SUM_W       = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mad_pkg::win_cmd_t             cmd_i,
  input  logic        [LEN_W-1:0]       len_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SUM_W-1:0]       sum_next_o
);

  localparam int unsigned PTR_W = $clog2(MAX_WINDOW);

  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rdata_q;
  logic                          rvld_q;
  logic        [MAX_WINDOW-1:0]  vld_q, vld_d;
  logic        [PTR_W-1:0]       pos_q, pos_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic signed [SAMPLE_BITS-1:0] oldest;
  logic        [LEN_W-1:0]       pos_inc;

  // sample memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      mem[pos_q] <= sample_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[pos_q];
    end
  end

  // slots never written since the last clear read as zero
  assign oldest = rvld_q ? rdata_q : '0;

  // running sum with the oldest sample swapped for the new one
  assign sum_next_o = sum_q - SUM_W'(oldest) + SUM_W'(sample_i);

  // ring position wraps at the window length
  assign pos_inc = LEN_W'(pos_q) + LEN_W'(1);

  always_comb begin
    vld_d = vld_q;
    pos_d = pos_q;
    sum_d = sum_q;
    priority if (cmd_i.clear) begin
      vld_d = '0;
      pos_d = '0;
      sum_d = '0;
    end else if (cmd_i.upd) begin
      vld_d[pos_q] = 1'b1;
      pos_d = (pos_inc >= len_i) ? '0 : PTR_W'(pos_inc);
      sum_d = sum_next_o;
    end else begin
      vld_d = vld_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      pos_q  <= '0;
      sum_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      pos_q <= pos_d;
      sum_q <= sum_d;
      if (cmd_i.rd_en) begin
        rvld_q <= vld_q[pos_q];
      end
    end
  end

  // clear empties the ring
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (sum_q == '0) && (pos_q == '0) && (vld_q == '0))
    else $error("window clear did not take effect");

  // write position stays inside the window
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(cmd_i.clear) && !cmd_i.clear) |-> (LEN_W'(pos_q) < len_i))
    else $error("write position beyond window length");

  // an update always follows a fetch of the same slot
  a_rd_before_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd |-> $past(cmd_i.rd_en))
    else $error("update without fetch");

endmodule

// ===== design/mad_divider.sv =====
module mad_divider #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned LEN_W       = 6,
  parameter int unsigned SUM_W       = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SUM_W-1:0]       dividend_i,
  input  logic        [LEN_W-1:0]       divisor_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(SUM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [LEN_W-1:0]  div_q, div_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [LEN_W:0]    trial;
  logic [LEN_W:0]    diff;
  logic              ge;
  logic [SUM_W-1:0]  quo_signed;

  // one restoring step: shift in the next dividend bit, try to subtract
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    priority if (start_i) begin
      // divide the magnitude so the quotient truncates toward zero
      busy_d = 1'b1;
      neg_d  = dividend_i[SUM_W-1];
      cnt_d  = CNT_W'(SUM_W - 1);
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
    end else if (busy_q) begin
      rem_d = ge ? LEN_W'(diff) : LEN_W'(trial);
      quo_d = {quo_q[SUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  // restore the sign of the quotient
  assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
  assign quotient_o = quo_signed[SAMPLE_BITS-1:0];
  assign done_o     = done_q;

  // a new divide never starts over a running one
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  // done is raised in the cycle after the last step
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && $past(busy_q) && ($past(cnt_q) == '0)))
    else $error("divider done without finishing");

  // divisor never zero while dividing
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (div_q != '0))
    else $error("divide by zero");

endmodule

// ===== design/moving_average_filter.sv =====
// Simple moving average over the most recent window_length samples.
//
// Input request: sample_i (signed) on sample_valid_i / sample_ready_o.
// Result request: average_o (signed) on average_valid_o / average_ready_i.
// Each sample gives exactly one average: the sum of the last window_length
// samples divided by window_length, truncated toward zero. Samples missing
// since reset or since the last length write count as zero.
// From sample accept to average valid: one memory read, one sum update,
// SUM_W = SAMPLE_BITS + log2(MAX_WINDOW) steps of the serial restoring
// divider, its registered done flag, and the output load. The divider is
// the slowest part and limits how often a new sample is taken.
// sample_ready_o is low from accept until the result is moved to the output
// register. If the receiver stalls, the finished average waits in the output
// register and the next sample is still taken; its own result waits in the
// divider until the output register frees up.
// cfg_we_i / cfg_wdata_i write the window length (0 acts as 1, values above
// MAX_WINDOW clip to it) and clear the window; write only while idle.
// Reset: window length 8, window empty, sum zero, no result pending.
module moving_average_filter #(
  parameter int unsigned MAX_WINDOW  = 32,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sample_valid_i,
  output logic                          sample_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          average_valid_o,
  input  logic                          average_ready_i,
  output logic signed [SAMPLE_BITS-1:0] average_o,
  input  logic                          cfg_we_i,
  input  logic [mad_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned LEN_W     = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W     = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int unsigned RESET_LEN = (mad_pkg::RESET_WINDOW > MAX_WINDOW) ?
                                      MAX_WINDOW : mad_pkg::RESET_WINDOW;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic        [LEN_W-1:0]       len_q, len_d;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] average_q;
  logic                          out_valid_q, out_valid_d;
  logic                          out_load;
  logic                          accept;
  mad_pkg::win_cmd_t             win_cmd;
  logic signed [SUM_W-1:0]       sum_next;
  logic                          div_done;
  logic signed [SAMPLE_BITS-1:0] div_quot;

  assign accept = sample_valid_i && sample_ready_o;

  // window length write with clipping
  always_comb begin
    len_d = len_q;
    if (cfg_we_i) begin
      priority if (cfg_wdata_i == '0) begin
        len_d = LEN_W'(1);
      end else if (int'(cfg_wdata_i) > MAX_WINDOW) begin
        len_d = LEN_W'(MAX_WINDOW);
      end else begin
        len_d = LEN_W'(cfg_wdata_i);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || average_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign sample_ready_o = (state_q == ST_IDLE);

  assign win_cmd.clear = cfg_we_i;
  assign win_cmd.rd_en = (state_q == ST_READ);
  assign win_cmd.upd   = (state_q == ST_UPDATE);

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (average_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_W'(RESET_LEN);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
    if (out_load) begin
      average_q <= div_quot;
    end
  end

  mad_window #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEN_W       (LEN_W),
    .SUM_W       (SUM_W)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (win_cmd),
    .len_i      (len_q),
    .sample_i   (sample_q),
    .sum_next_o (sum_next)
  );

  mad_divider #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEN_W       (LEN_W),
    .SUM_W       (SUM_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (win_cmd.upd),
    .dividend_i (sum_next),
    .divisor_i  (len_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign average_valid_o = out_valid_q;
  assign average_o       = average_q;

  // one sample at a time
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !sample_ready_o)
    else $error("second sample accepted while busy");

  // a finished result waits while the output register is held
  a_hold_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && out_valid_q && !average_ready_i) |=>
      (state_q == ST_FINISH))
    else $error("result dropped over a stalled output");

  // divider completion only while waiting for it
  a_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVIDE))
    else $error("divider finished outside divide phase");

  // window length stays in range
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) && (int'(len_q) <= MAX_WINDOW))
    else $error("window length out of range");

endmodule
